### hdl/fir_conv_pkg.sv
// Shared constants and types for the streaming FIR convolution block.
// Used by the channel interfaces and the fir_convolution top level.
// No dependencies.
package fir_conv_pkg;

    // Default sizes of the filter
    localparam int MAX_TAPS_DEF    = 128;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;

    // Fixed field widths
    localparam int ACC_BITS   = 48;
    localparam int TAPS_BITS  = 8;
    localparam int INDEX_BITS = 7;

    // Filter length after reset
    localparam logic [TAPS_BITS-1:0] TAPS_RESET = 8'd101;

    // Item opcodes
    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

endpackage

### hdl/fir_conv_if.sv
// Valid/ready channel interfaces for the FIR convolution block: input items,
// result items and the filter length register write.
// Depends on fir_conv_pkg.
interface fir_conv_in_if
    import fir_conv_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    mode_t                         mode;
    logic [INDEX_BITS-1:0]         coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, mode, coef_index, coef_value, sample_value,
                    input ready);
    modport sink   (input valid, mode, coef_index, coef_value, sample_value,
                    output ready);
endinterface

interface fir_conv_out_if
    import fir_conv_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [ACC_BITS-1:0] filtered_value;

    modport source (output valid, filtered_value, input ready);
    modport sink   (input valid, filtered_value, output ready);
endinterface

interface fir_conv_cfg_if
    import fir_conv_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [TAPS_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/fir_convolution.sv
// Streaming direct-form FIR filter with a single shared multiply-accumulate.
// Depends on fir_conv_pkg and the channel interfaces in fir_conv_if.sv.
//
// A sample or flush item pushes one sample into the history and produces one
// result: the sum over the taps in use of coefficient j times the sample j
// steps back, wrapped to 48 bits. One multiplier walks the taps one per cycle,
// and each tap read is registered, multiplied into the product register and
// added to the accumulator. The sum is then loaded into the output register
// once that is free, and the input is not ready until then. Load and clear
// items produce no result. The output register lets the next item start
// while a result waits to be taken. History clearing (reset or clear item)
// is done with a fill count, so it is immediate and needs no sweep of the
// memory. Coefficient slots read before being loaded give undefined products.
module fir_convolution
    import fir_conv_pkg::*;
#(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    fir_conv_in_if.sink    item_in,
    fir_conv_out_if.source result_out,
    fir_conv_cfg_if.sink   cfg
);

    localparam int HW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int JW  = $clog2(MAX_TAPS + 1);
    localparam int CW  = (JW > TAPS_BITS) ? JW : TAPS_BITS;
    localparam int LW  = ((HW > INDEX_BITS) ? HW : INDEX_BITS) + 1;
    localparam int PW  = SAMPLE_BITS + COEF_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Storage
    logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

    // Control registers
    state_t               state_reg, state_next;
    logic [TAPS_BITS-1:0] taps_reg, taps_next;
    logic [HW-1:0]        head_reg, head_next;
    logic [JW-1:0]        fill_reg, fill_next;
    logic [JW-1:0]        tap_reg, tap_next;
    logic                 v1_reg, v1_next;
    logic                 live1_reg, live1_next;
    logic                 v2_reg, v2_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [HW-1:0]                 idx_reg, idx_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]    filtered_reg, filtered_next;
    logic signed [COEF_BITS-1:0]   coef_rd_reg;
    logic signed [SAMPLE_BITS-1:0] hist_rd_reg;

    // Decode helpers
    logic                          accept_in;
    logic                          out_fire;
    logic [HW-1:0]                 head_adv;
    logic [CW-1:0]                 taps_wide;
    logic [JW-1:0]                 taps_eff;
    logic                          last_tap;
    logic [LW-1:0]                 load_idx;
    logic                          load_ok;
    logic                          coef_we;
    logic                          hist_we;
    logic signed [SAMPLE_BITS-1:0] hist_wdata;
    logic signed [SAMPLE_BITS-1:0] x_sel;

    assign accept_in = item_in.valid && item_in.ready;
    assign out_fire  = result_out.valid && result_out.ready;

    assign item_in.ready             = (state_reg == ST_IDLE);
    assign cfg.ready                 = 1'b1;
    assign result_out.valid          = out_valid_reg;
    assign result_out.filtered_value = filtered_reg;

    // Clamp the filter length to 1..MAX_TAPS
    assign taps_wide = CW'(taps_reg);
    always_comb
    begin
        if (taps_wide == '0)
            taps_eff = JW'(1);
        else if (taps_wide > CW'(MAX_TAPS))
            taps_eff = JW'(MAX_TAPS);
        else
            taps_eff = JW'(taps_wide);
    end
    assign last_tap = (tap_reg == taps_eff - JW'(1));

    // Circular history pointer advance
    assign head_adv = (head_reg == HW'(MAX_TAPS - 1)) ? '0 : head_reg + HW'(1);

    // Memory write controls; slots past the store are dropped
    assign load_idx   = LW'(item_in.coef_index);
    assign load_ok    = (load_idx < LW'(MAX_TAPS));
    assign coef_we    = accept_in && (item_in.mode == MODE_LOAD) && load_ok;
    assign hist_we    = accept_in && ((item_in.mode == MODE_SAMPLE)
                                   || (item_in.mode == MODE_FLUSH));
    assign hist_wdata = (item_in.mode == MODE_SAMPLE) ? item_in.sample_value : '0;

    // Zero history entries older than the fill count
    assign x_sel = live1_reg ? hist_rd_reg : '0;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        taps_next      = taps_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        tap_next       = tap_reg;
        v1_next        = (state_reg == ST_RUN);
        live1_next     = (tap_reg < fill_reg);
        v2_next        = v1_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        prod_next      = PW'(x_sel) * PW'(coef_rd_reg);
        filtered_next  = filtered_reg;

        if (cfg.valid && cfg.ready)
            taps_next = cfg.data;

        if (out_fire)
            out_valid_next = 1'b0;

        // Accumulate one product per cycle
        if (v2_reg)
            acc_next = acc_reg + ACC_BITS'(prod_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    unique case (item_in.mode) inside
                        MODE_LOAD:
                        begin
                        end
                        MODE_SAMPLE, MODE_FLUSH:
                        begin
                            head_next  = head_adv;
                            idx_next   = head_adv;
                            fill_next  = (fill_reg == JW'(MAX_TAPS)) ? fill_reg
                                                                     : fill_reg + JW'(1);
                            tap_next   = '0;
                            acc_next   = '0;
                            state_next = ST_RUN;
                        end
                        MODE_CLEAR:
                        begin
                            head_next = '0;
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // Issue one tap read per cycle, newest sample first
                tap_next = tap_reg + JW'(1);
                idx_next = (idx_reg == '0) ? HW'(MAX_TAPS - 1) : idx_reg - HW'(1);
                if (last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    filtered_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            taps_reg      <= TAPS_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            tap_reg       <= '0;
            v1_reg        <= 1'b0;
            live1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taps_reg      <= taps_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            tap_reg       <= tap_next;
            v1_reg        <= v1_next;
            live1_reg     <= live1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        filtered_reg <= filtered_next;
    end

    // Coefficient store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[load_idx[HW-1:0]] <= item_in.coef_value;
        coef_rd_reg <= coef_mem[tap_reg[HW-1:0]];
    end

    // Sample history: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[head_adv] <= hist_wdata;
        hist_rd_reg <= hist_mem[idx_reg];
    end

endmodule

### sim/tb_fir_convolution.sv
// Self-checking testbench for fir_convolution: directed items from a table,
// then random coefficient, sample, flush and clear items across filter lengths.
// Depends on fir_conv_pkg, the channel interfaces and the fir_convolution RTL.
module tb_fir_convolution;
    import fir_conv_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 112;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_SHORT = 8;
    localparam int DRAIN_FINAL = 150;

    typedef logic signed [ACC_BITS-1:0] acc_t;
    typedef logic signed [COEF_BITS_DEF-1:0] coef_t;
    typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

    // One directed item, with an optional hand-computed result
    typedef struct packed {
        mode_t                 mode;
        logic [INDEX_BITS-1:0] index;
        coef_t                 coef;
        sample_t               sample;
        logic                  typed;
        acc_t                  result;
    } stim_row_t;

    logic clk;
    logic rst_n;

    fir_conv_in_if  item_if ();
    fir_conv_out_if result_if ();
    fir_conv_cfg_if taps_if ();

    fir_convolution dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (taps_if)
    );

    // Filter state mirrored by the predictor
    coef_t                coef_mem [MAX_TAPS_DEF];
    sample_t              hist_mem [MAX_TAPS_DEF];
    int                   hist_head = 0;
    logic [TAPS_BITS-1:0] taps_reg = TAPS_RESET;

    acc_t expected_filtered [$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  taps_written    = 0;
    int  cycle_count     = 0;
    int  burst_left      = 0;
    bit  hold_req        = 1'b0;

    // Directed items, run with a filter length of 3
    stim_row_t directed_rows [0:20] = '{
        '{MODE_LOAD,   7'd0,   18'sd131071,  16'sd0,      1'b0, 48'sd0},
        '{MODE_LOAD,   7'd1,   -18'sd131072, 16'sd0,      1'b0, 48'sd0},
        '{MODE_LOAD,   7'd2,   18'sd1,       16'sd0,      1'b0, 48'sd0},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       16'sd32767,  1'b1, 48'sd4294803457},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       -16'sd32768, 1'b0, 48'sd0},
        '{MODE_FLUSH,  7'd0,   18'sd0,       16'sd0,      1'b0, 48'sd0},
        '{MODE_FLUSH,  7'd0,   18'sd0,       16'sd0,      1'b0, 48'sd0},
        '{MODE_FLUSH,  7'd0,   18'sd0,       16'sd0,      1'b1, 48'sd0},
        '{MODE_CLEAR,  7'd0,   18'sd0,       16'sd0,      1'b0, 48'sd0},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       16'sd1,      1'b1, 48'sd131071},
        '{MODE_SAMPLE, 7'd127, -18'sd1,      16'sd0,      1'b1, -48'sd131072},
        '{MODE_LOAD,   7'd127, -18'sd1,      -16'sd32768, 1'b0, 48'sd0},
        '{MODE_LOAD,   7'd2,   18'sd0,       -16'sd1,     1'b0, 48'sd0},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       -16'sd1,     1'b0, 48'sd0},
        '{MODE_CLEAR,  7'd127, -18'sd131072, 16'sd32767,  1'b0, 48'sd0},
        '{MODE_FLUSH,  7'd0,   18'sd0,       -16'sd1,     1'b1, 48'sd0},
        '{MODE_LOAD,   7'd0,   -18'sd1,      16'sd0,      1'b0, 48'sd0},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       -16'sd32768, 1'b1, 48'sd32768},
        '{MODE_FLUSH,  7'd0,   18'sd0,       16'sd0,      1'b0, 48'sd0},
        '{MODE_LOAD,   7'd1,   18'sd0,       16'sd0,      1'b0, 48'sd0},
        '{MODE_SAMPLE, 7'd0,   18'sd0,       16'sd21845,  1'b0, 48'sd0}
    };

    // Clamp the length register to the range the filter honors
    function automatic int eff_taps();
        if (taps_reg == 0)
            return 1;
        if (taps_reg > MAX_TAPS_DEF)
            return MAX_TAPS_DEF;
        return int'(taps_reg);
    endfunction

    // Apply one item to the mirrored state; return 1 when it yields a result
    function automatic bit fir_predict(input mode_t m, input logic [INDEX_BITS-1:0] idx,
                                       input coef_t cv, input sample_t sv,
                                       output acc_t acc);
        int   pos;
        int   taps;
        acc_t prod;
        acc = '0;
        if (m == MODE_LOAD)
        begin
            coef_mem[idx] = cv;
            return 1'b0;
        end
        if (m == MODE_CLEAR)
        begin
            foreach (hist_mem[i])
                hist_mem[i] = '0;
            hist_head = 0;
            return 1'b0;
        end
        taps = eff_taps();
        hist_head = (hist_head + 1) % MAX_TAPS_DEF;
        hist_mem[hist_head] = (m == MODE_SAMPLE) ? sv : '0;
        pos = hist_head;
        for (int j = 0; j < taps; j++)
        begin
            prod = acc_t'(hist_mem[pos]) * acc_t'(coef_mem[j]);
            acc  = acc + prod;
            pos  = (pos == 0) ? MAX_TAPS_DEF - 1 : pos - 1;
        end
        return 1'b1;
    endfunction

    // Random sample, biased toward the extremes
    function automatic sample_t rand_sample();
        case ($urandom_range(0, 15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '1;
            3:       return '0;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Random coefficient, biased toward the extremes
    function automatic coef_t rand_coef();
        case ($urandom_range(0, 15))
            0:       return 18'sh1FFFF;
            1:       return 18'sh20000;
            2:       return '1;
            3:       return '0;
            default: return coef_t'($urandom);
        endcase
    endfunction

    // Offer one item in bursts with random gaps; predict once it is taken
    task automatic send_item(input mode_t m, input logic [INDEX_BITS-1:0] idx,
                             input coef_t cv, input sample_t sv,
                             input bit use_typed, input acc_t typed_val);
        int   gap;
        acc_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid        <= 1'b1;
        item_if.mode         <= m;
        item_if.coef_index   <= idx;
        item_if.coef_value   <= cv;
        item_if.sample_value <= sv;
        do @(posedge clk); while (!item_if.ready);
        items_sent++;
        if (fir_predict(m, idx, cv, sv, predicted))
            expected_filtered.push_back(use_typed ? typed_val : predicted);
    endtask

    // Drop valid and hold until every result is back, then let the block settle
    task automatic wait_idle(input int settle);
        item_if.valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the filter length register
    task automatic write_taps(input logic [TAPS_BITS-1:0] v);
        taps_if.valid <= 1'b1;
        taps_if.data  <= v;
        do @(posedge clk); while (!taps_if.ready);
        taps_if.valid <= 1'b0;
        taps_reg = v;
        taps_written++;
    endtask

    // Mostly sample runs with flush tails, mixed with stray items of any mode
    task automatic run_phase(input int budget);
        int start;
        int n;
        int tail;
        int taps;
        taps  = eff_taps();
        start = items_sent;
        while (items_sent - start < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(MODE_CLEAR, INDEX_BITS'($urandom), rand_coef(), rand_sample(),
                              1'b0, '0);
                n = $urandom_range(1, 16);
                repeat (n)
                    send_item(MODE_SAMPLE, INDEX_BITS'($urandom), rand_coef(), rand_sample(),
                              1'b0, '0);
                if ($urandom_range(0, 7) == 0)
                    tail = taps - 1;
                else
                    tail = $urandom_range(0, (taps - 1 < 8) ? taps - 1 : 8);
                repeat (tail)
                    send_item(MODE_FLUSH, INDEX_BITS'($urandom), rand_coef(), rand_sample(),
                              1'b0, '0);
            end
            else
            begin
                send_item(mode_t'($urandom_range(0, 3)), INDEX_BITS'($urandom), rand_coef(),
                          rand_sample(), 1'b0, '0);
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results still pending", cycle_count,
                   expected_filtered.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result receiver: rotate through stall patterns, hold off on request
    initial
    begin
        int hold_left;
        int tick;
        hold_left = 0;
        tick = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                case ((tick / 400) % 4)
                    0:       result_if.ready <= 1'b1;
                    1:       result_if.ready <= 1'($urandom_range(0, 1));
                    2:       result_if.ready <= (tick % 3 == 0);
                    default: result_if.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        acc_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_checked++;
            if (expected_filtered.size() == 0)
            begin
                error_count++;
                $error("filtered_value: unexpected result %0d with nothing pending",
                       result_if.filtered_value);
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (result_if.filtered_value !== want)
                begin
                    error_count++;
                    $error("filtered_value mismatch: expected %0d, actual %0d", want,
                           result_if.filtered_value);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int taps_plan [8];
        int directed_count;
        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.mode         = MODE_LOAD;
        item_if.coef_index   = '0;
        item_if.coef_value   = '0;
        item_if.sample_value = '0;
        taps_if.valid        = 1'b0;
        taps_if.data         = '0;
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short filter so the directed part only needs three coefficients
        write_taps(8'd3);
        foreach (directed_rows[r])
            send_item(directed_rows[r].mode, directed_rows[r].index, directed_rows[r].coef,
                      directed_rows[r].sample, directed_rows[r].typed, directed_rows[r].result);
        directed_count = items_sent;
        wait_idle(DRAIN_SHORT);

        // Fill every coefficient slot before any longer filter reads them
        for (int s = 0; s < MAX_TAPS_DEF; s++)
            send_item(MODE_LOAD, INDEX_BITS'(s), rand_coef(), rand_sample(), 1'b0, '0);
        wait_idle(DRAIN_SHORT);

        // Sweep filter lengths: extremes, out-of-range values, reset value, random
        taps_plan = '{128, 1, 0, 255, 101, 200, $urandom_range(2, 127), $urandom_range(2, 64)};
        foreach (taps_plan[p])
        begin
            write_taps(taps_plan[p][TAPS_BITS-1:0]);
            if (taps_plan[p] == 1)
                hold_req <= 1'b1;
            run_phase(PHASE_ITEMS);
            wait_idle(DRAIN_SHORT);
        end
        repeat (DRAIN_FINAL) @(posedge clk);

        $display("Run sent %0d items (%0d directed) and checked %0d results", items_sent,
                 directed_count, results_checked);
        $display("Filter length written %0d times, including 0, 1, 128, 200 and 255",
                 taps_written);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
